/* hw/rtl/gaussian_prime_test_defines.svh */
// Assertion macros for the Gaussian prime test block.
// Included by the RTL files that assert; no other dependencies.
`ifndef GAUSSIAN_PRIME_TEST_DEFINES_SVH
`define GAUSSIAN_PRIME_TEST_DEFINES_SVH
`ifndef SYNTHESIS
`define GPT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define GPT_ASSERT_NR(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define GPT_ASSERT(label, clk, rst_n, prop)
`define GPT_ASSERT_NR(label, clk, prop)
`endif
`endif

/* hw/rtl/gpt_pkg.sv */
// Package for the Gaussian prime test: state encoding, constants, tables.
// No dependencies.
`default_nettype none
package gpt_pkg;
	localparam int NW = 64;
	localparam logic [63:0] SPLIT1 = 64'd25326001;
	localparam logic [63:0] SPLIT2 = 64'd3215031751;
	localparam logic [63:0] WIDE_LIMIT = 64'h1_0000_0000;
	localparam logic [63:0] TRIAL_SQ = 64'd9409;
	localparam int NUM_TRIAL = 24;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQA, ST_SQB, ST_SUM, ST_CHECK, ST_TRIAL, ST_TRIAL_END,
		ST_DECOMP, ST_WIT, ST_POW_INIT, ST_POW_STEP, ST_POW_MR, ST_POW_MB,
		ST_POW_CHK, ST_SQR, ST_SQR_CHK, ST_NEXTW, ST_DONE
	} state_t;

	function automatic logic [6:0] trial_prime(input logic [4:0] i);
		case (i)
			5'd0: trial_prime = 7'd3;   5'd1: trial_prime = 7'd5;
			5'd2: trial_prime = 7'd7;   5'd3: trial_prime = 7'd11;
			5'd4: trial_prime = 7'd13;  5'd5: trial_prime = 7'd17;
			5'd6: trial_prime = 7'd19;  5'd7: trial_prime = 7'd23;
			5'd8: trial_prime = 7'd29;  5'd9: trial_prime = 7'd31;
			5'd10: trial_prime = 7'd37; 5'd11: trial_prime = 7'd41;
			5'd12: trial_prime = 7'd43; 5'd13: trial_prime = 7'd47;
			5'd14: trial_prime = 7'd53; 5'd15: trial_prime = 7'd59;
			5'd16: trial_prime = 7'd61; 5'd17: trial_prime = 7'd67;
			5'd18: trial_prime = 7'd71; 5'd19: trial_prime = 7'd73;
			5'd20: trial_prime = 7'd79; 5'd21: trial_prime = 7'd83;
			5'd22: trial_prime = 7'd89; 5'd23: trial_prime = 7'd97;
			default: trial_prime = 7'd3;
		endcase
	endfunction

	function automatic logic [5:0] witness(input logic [3:0] i);
		case (i)
			4'd0: witness = 6'd2;   4'd1: witness = 6'd3;
			4'd2: witness = 6'd5;   4'd3: witness = 6'd7;
			4'd4: witness = 6'd11;  4'd5: witness = 6'd13;
			4'd6: witness = 6'd17;  4'd7: witness = 6'd19;
			4'd8: witness = 6'd23;  4'd9: witness = 6'd29;
			4'd10: witness = 6'd31; 4'd11: witness = 6'd37;
			default: witness = 6'd2;
		endcase
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/gpt_mulmod.sv */
// Bit-serial modular multiplier: acc = x*y mod m, one bit of y per cycle.
// Depends on gpt_pkg. Inputs x, y must be below m; all three are latched at start.
`default_nettype none
module gpt_mulmod (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [gpt_pkg::NW-1:0] x,
	input  wire logic [gpt_pkg::NW-1:0] y,
	input  wire logic [gpt_pkg::NW-1:0] m,
	output logic done,
	output logic [gpt_pkg::NW-1:0] prod
);
	import gpt_pkg::*;
	`include "gaussian_prime_test_defines.svh"

	logic [NW-1:0] acc_q, x_q, y_q, m_q;
	logic [6:0] cnt_q;
	logic run_q;
	logic [NW:0] dbl, dsub, add1, asub;
	logic [NW-1:0] a2, a3;

	// double, reduce, then conditionally add x, reduce (65-bit sums)
	always_comb begin
		dbl = {acc_q, 1'b0};
		dsub = dbl - {1'b0, m_q};
		a2 = dsub[NW] ? dbl[NW-1:0] : dsub[NW-1:0];
		add1 = {1'b0, a2} + {1'b0, x_q};
		asub = add1 - {1'b0, m_q};
		a3 = y_q[NW-1] ? (asub[NW] ? add1[NW-1:0] : asub[NW-1:0]) : a2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 7'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q <= x;
			y_q <= y;
			m_q <= m;
		end else if (run_q) begin
			acc_q <= a3;
			y_q <= {y_q[NW-2:0], 1'b0};
		end
	end

	assign prod = acc_q;

	`GPT_ASSERT(a_done_after_run, clk, arst_n, done |-> $past(run_q))
	`GPT_ASSERT(a_acc_below_m, clk, arst_n, (run_q && !start) |=> (acc_q < m_q))
	`GPT_ASSERT(a_no_restart, clk, arst_n, start |=> run_q)
endmodule
`default_nettype wire

/* hw/rtl/gaussian_prime_test.sv */
// Top level of the Gaussian prime test: sequencer around a bit-serial mulmod.
// Depends on gpt_pkg, gpt_mulmod and gaussian_prime_test_defines.svh.
//
//  channel | ports                          | handshake
//  in      | real_part, imag_part           | start && !busy
//  out     | is_gaussian_prime              | done strobe, one cycle
//
// One item at a time; busy stays high from accept to the cycle before the done strobe.
// Each modular multiply runs in the one shared 1-bit-per-cycle unit;
// trial division works through up to 24 primes, each as 64 remainder bits and a check.
// A full 64-bit test is 12 witnesses * up to 124 multiplies; far fewer for small
// norms. Reset clears the control state; results cannot be stalled.
`default_nettype none
module gaussian_prime_test (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic signed [31:0] real_part,
	input  wire logic signed [31:0] imag_part,
	output logic done,
	output logic is_gaussian_prime
);
	import gpt_pkg::*;
	`include "gaussian_prime_test_defines.svh"

	state_t state_q, state_d;
	logic [31:0] ma_q, mb_q;
	logic axis_q;
	logic [NW-1:0] n_q, acc_q, odd_q, e_q, x_q, base_q, nm1;
	logic [6:0] twos_q, k_q;
	logic [4:0] ti_q;
	logic [6:0] rem_q;
	logic [6:0] bc_q;
	logic [3:0] wi_q, wcnt_q;
	logic res_q;
	logic mm_start, mm_done;
	logic sqa_go_q;
	logic [NW-1:0] mx, my, mm_m, mprod;
	logic [31:0] abs_a, abs_b;
	logic [7:0] rem2;
	logic [6:0] rem_n, tp;
	logic [NW-1:0] wv;

	assign abs_a = real_part[31] ? (~real_part + 32'd1) : real_part;
	assign abs_b = imag_part[31] ? (~imag_part + 32'd1) : imag_part;
	assign nm1 = n_q - 64'd1;
	assign tp = trial_prime(ti_q);
	assign wv = {58'd0, witness(wi_q)};

	// one remainder bit per cycle
	always_comb begin
		rem2 = {rem_q, n_q[6'd63 - bc_q[5:0]]};
		rem_n = (rem2 >= {1'b0, tp}) ? 7'(rem2 - {1'b0, tp}) : rem2[6:0];
	end

	gpt_mulmod u_mm (
		.clk(clk), .arst_n(arst_n), .start(mm_start), .x(mx), .y(my), .m(mm_m),
		.done(mm_done), .prod(mprod)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_SQA;
			ST_SQA: if (axis_q) state_d = ST_CHECK;
				else if (mm_done) state_d = ST_SQB;
			ST_SQB: if (mm_done) state_d = ST_SUM;
			ST_SUM: state_d = ST_CHECK;
			ST_CHECK: begin
				if (n_q < 64'd4 || !n_q[0] || (axis_q && n_q[1:0] != 2'b11))
					state_d = ST_DONE;
				else state_d = ST_TRIAL;
			end
			ST_TRIAL: if (bc_q == 7'd63) state_d = ST_TRIAL_END;
			ST_TRIAL_END: begin
				if (n_q == {57'd0, tp} || rem_q == 7'd0) state_d = ST_DONE;
				else if (ti_q == 5'(NUM_TRIAL - 1))
					state_d = (n_q < TRIAL_SQ) ? ST_DONE : ST_DECOMP;
				else state_d = ST_TRIAL;
			end
			ST_DECOMP: if (odd_q[0]) state_d = ST_WIT;
			ST_WIT: state_d = (wi_q == wcnt_q) ? ST_DONE :
				((wv >= n_q) ? ST_NEXTW : ST_POW_INIT);
			ST_POW_INIT: state_d = ST_POW_STEP;
			ST_POW_STEP: state_d = (e_q == 64'd0) ? ST_POW_CHK :
				(e_q[0] ? ST_POW_MR : ST_POW_MB);
			ST_POW_MR: if (mm_done) state_d = ST_POW_MB;
			ST_POW_MB: if (mm_done) state_d = ST_POW_STEP;
			ST_POW_CHK: state_d = (x_q == 64'd1 || x_q == nm1) ? ST_NEXTW : ST_SQR_CHK;
			ST_SQR_CHK: state_d = (k_q >= twos_q) ? ST_DONE : ST_SQR;
			ST_SQR: if (mm_done) state_d = (mprod == nm1) ? ST_NEXTW : ST_SQR_CHK;
			ST_NEXTW: state_d = ST_WIT;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// multiplier operands follow the state being entered; the unit latches them at launch.
	// Squaring the parts needs no reduction, so the modulus is all ones there.
	always_comb begin
		mm_start = 1'b0;
		mx = x_q;
		my = base_q;
		mm_m = n_q;
		case (state_d)
			ST_SQA: begin mx = {32'd0, ma_q}; my = {32'd0, ma_q}; mm_m = '1; end
			ST_SQB: begin mx = {32'd0, mb_q}; my = {32'd0, mb_q}; mm_m = '1; end
			ST_POW_MB: begin mx = base_q; my = base_q; end
			ST_SQR: begin mx = x_q; my = x_q; end
			default: ;
		endcase
		if (state_d != state_q) begin
			case (state_d)
				ST_SQB, ST_POW_MR, ST_POW_MB, ST_SQR: mm_start = 1'b1;
				default: ;
			endcase
		end
		// ST_SQA launches itself in the cycle after accept
		if (sqa_go_q && !axis_q) mm_start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sqa_go_q <= 1'b0;
			done <= 1'b0;
			is_gaussian_prime <= 1'b0;
		end else begin
			state_q <= state_d;
			sqa_go_q <= (state_q == ST_IDLE) && start;
			done <= (state_q == ST_DONE);
			if (state_q == ST_DONE) is_gaussian_prime <= res_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (start) begin
				ma_q <= abs_a;
				mb_q <= abs_b;
				axis_q <= (abs_a == 32'd0) || (abs_b == 32'd0);
				n_q <= {32'd0, (abs_a == 32'd0) ? abs_b : abs_a};
				res_q <= 1'b0;
				ti_q <= '0;
				bc_q <= '0;
				rem_q <= '0;
			end
			ST_SQA: if (mm_done) acc_q <= mprod;
			ST_SQB: if (mm_done) n_q <= acc_q + mprod;
			ST_SUM: ;
			ST_CHECK: begin
				res_q <= (n_q == 64'd2 || n_q == 64'd3) && !axis_q
					|| (axis_q && n_q == 64'd3);
				bc_q <= '0;
				rem_q <= '0;
			end
			ST_TRIAL: begin
				rem_q <= rem_n;
				bc_q <= bc_q + 7'd1;
			end
			ST_TRIAL_END: begin
				res_q <= (n_q == {57'd0, tp}) || (ti_q == 5'(NUM_TRIAL - 1) &&
					rem_q != 7'd0 && n_q < TRIAL_SQ);
				ti_q <= ti_q + 5'd1;
				bc_q <= '0;
				rem_q <= '0;
				odd_q <= nm1;
				twos_q <= '0;
				wi_q <= '0;
				wcnt_q <= (n_q >= WIDE_LIMIT) ? 4'd12 :
					(n_q < SPLIT1) ? 4'd3 : (n_q < SPLIT2) ? 4'd4 : 4'd5;
			end
			ST_DECOMP: if (!odd_q[0]) begin
				odd_q <= {1'b0, odd_q[NW-1:1]};
				twos_q <= twos_q + 7'd1;
			end
			ST_WIT: if (wi_q == wcnt_q) res_q <= 1'b1;
			ST_POW_INIT: begin
				x_q <= 64'd1;
				base_q <= wv;
				e_q <= odd_q;
				k_q <= 7'd1;
			end
			ST_POW_MR: if (mm_done) x_q <= mprod;
			ST_POW_MB: if (mm_done) begin
				base_q <= mprod;
				e_q <= {1'b0, e_q[NW-1:1]};
			end
			ST_SQR: if (mm_done) begin
				x_q <= mprod;
				k_q <= k_q + 7'd1;
			end
			ST_SQR_CHK: if (k_q >= twos_q) res_q <= 1'b0;
			ST_NEXTW: wi_q <= wi_q + 4'd1;
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	`GPT_ASSERT(a_done_one, clk, arst_n, done |=> !done)
	`GPT_ASSERT(a_busy_accept, clk, arst_n, (start && !busy) |=> busy)
	`GPT_ASSERT(a_done_idle, clk, arst_n, done |-> !busy)
endmodule
`default_nettype wire

/* dv/gaussian_prime_checker.sv */
// Checker for the Gaussian prime test: predicts each verdict from accepted inputs.
// Compares done strobes in order; depends only on the block's port list.
`timescale 1ns / 100ps
module gaussian_prime_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic busy,
	input  wire logic signed [31:0] real_part,
	input  wire logic signed [31:0] imag_part,
	input  wire logic done,
	input  wire logic is_gaussian_prime,
	output int errors,
	output int pending
);
	bit verdict_q[$];

	function automatic logic [63:0] mul_wrap(input logic [63:0] x, input logic [63:0] y,
			input logic [63:0] m);
		logic [127:0] p;
		p = {64'd0, x} * {64'd0, y};
		return 64'(p % {64'd0, m});
	endfunction

	function automatic logic [63:0] pow_wrap(input logic [63:0] b, input logic [63:0] e,
			input logic [63:0] m);
		logic [63:0] r;
		r = 64'd1;
		b = b % m;
		while (e != 0) begin
			if (e[0])
				r = mul_wrap(r, b, m);
			b = mul_wrap(b, b, m);
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic bit strong_pass(input logic [63:0] n, input logic [63:0] d,
			input int s, input logic [63:0] w);
		logic [63:0] x;
		if (w >= n)
			return 1;
		x = pow_wrap(w, d, n);
		if (x == 1 || x == n - 1)
			return 1;
		for (int k = 1; k < s; k++) begin
			x = mul_wrap(x, x, n);
			if (x == n - 1)
				return 1;
		end
		return 0;
	endfunction

	function automatic bit rational_prime(input logic [63:0] n);
		int odd_primes[24];
		int bases[12];
		logic [63:0] d;
		int s;
		int cnt;
		odd_primes = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67,
			71, 73, 79, 83, 89, 97};
		bases = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
		if (n < 2)
			return 0;
		if (n == 2 || n == 3)
			return 1;
		if (!n[0])
			return 0;
		foreach (odd_primes[i]) begin
			if (n == 64'(odd_primes[i]))
				return 1;
			if (n % 64'(odd_primes[i]) == 0)
				return 0;
		end
		if (n < 64'd9409)
			return 1;
		d = n - 1;
		s = 0;
		while (!d[0]) begin
			d = d >> 1;
			s++;
		end
		// narrow range uses the first 3..5 bases only
		if (n < 64'h1_0000_0000)
			cnt = (n < 64'd25326001) ? 3 : (n < 64'd3215031751) ? 4 : 5;
		else
			cnt = 12;
		for (int i = 0; i < cnt; i++)
			if (!strong_pass(n, d, s, 64'(bases[i])))
				return 0;
		return 1;
	endfunction

	function automatic logic [63:0] part_mag(input logic [31:0] v);
		return {32'd0, v[31] ? (~v + 32'd1) : v};
	endfunction

	function automatic bit gaussian_verdict(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] ma, mb, ax;
		ma = part_mag(a);
		mb = part_mag(b);
		if (ma == 0 || mb == 0) begin
			ax = ma | mb;
			return ax != 0 && ax[1:0] == 2'b11 && rational_prime(ax);
		end
		return rational_prime(ma * ma + mb * mb);
	endfunction

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			verdict_q.push_back(gaussian_verdict(real_part, imag_part));
		if (arst_n && done) begin
			if (verdict_q.size() == 0) begin
				$error("unexpected result transfer: is_gaussian_prime=%0d", is_gaussian_prime);
				errors++;
			end else begin
				bit want;
				want = verdict_q.pop_front();
				if (is_gaussian_prime !== want) begin
					$error("is_gaussian_prime mismatch: expected %0d actual %0d", want,
						is_gaussian_prime);
					errors++;
				end
			end
		end
		pending = verdict_q.size();
	end
endmodule

/* dv/gaussian_prime_test_test.sv */
// Top of the Gaussian prime test bench: clock, reset, stimulus and verdict.
// Depends on gaussian_prime_test (RTL) and gaussian_prime_checker.
`timescale 1ns / 100ps
module gaussian_prime_test_test;
	localparam longint CYCLE_LIMIT = 60_000_000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic signed [31:0] real_part = 0;
	logic signed [31:0] imag_part = 0;
	logic busy, done, is_gaussian_prime;
	int errors, pending;
	longint cycles = 0;

	always #5 clk = ~clk;

	gaussian_prime_test i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.real_part(real_part), .imag_part(imag_part),
		.done(done), .is_gaussian_prime(is_gaussian_prime)
	);

	gaussian_prime_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.real_part(real_part), .imag_part(imag_part),
		.done(done), .is_gaussian_prime(is_gaussian_prime),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 3);
		if (r < 92)
			return $urandom_range(4, 20);
		return $urandom_range(100, 400);
	endfunction

	function automatic logic [31:0] signed_in(input int span);
		return 32'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	// one transfer: start held until an edge with busy low; gap of zero keeps start high
	task automatic send_point(input logic [31:0] a, input logic [31:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start = 0;
			repeat (gap) @(negedge clk);
		end
		start = 1;
		real_part = a;
		imag_part = b;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	initial begin
		logic [31:0] ra, rb;
		int kind;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: zero, units, axes, extremes, bit patterns
		send_point(0, 0);
		send_point(1, 0);
		send_point(0, 1);
		send_point(-1, -1);
		send_point(3, 0);
		send_point(0, -3);
		send_point(5, 0);
		send_point(0, 7);
		send_point(32'h8000_0000, 0);
		send_point(0, 32'h8000_0000);
		send_point(32'h8000_0000, 32'h8000_0000);
		send_point(32'h7fff_ffff, 0);
		send_point(0, 32'h8000_0001);
		send_point(32'h7fff_ffff, 32'h7fff_ffff);
		send_point(32'h8000_0000, 32'h7fff_ffff);
		send_point(1, 1);
		send_point(2, 1);
		send_point(3, 10);
		send_point(97, 0);
		send_point(1, 32'h7fff_ffff);
		send_point(32'h5555_5555, 32'haaaa_aaaa);
		send_point(32'haaaa_aaaa, 32'h5555_5555);
		send_point(5000, 4999);
		for (int n = 0; n < 80; n++) begin
			kind = $urandom_range(0, 99);
			if (kind < 50) begin
				ra = signed_in(300);
				rb = signed_in(300);
			end else if (kind < 75) begin
				ra = signed_in(70000);
				rb = signed_in(70000);
			end else if (kind < 87) begin
				ra = $urandom;
				rb = 0;
				if ($urandom_range(0, 1)) begin
					rb = ra;
					ra = 0;
				end
			end else begin
				ra = $urandom;
				rb = $urandom;
			end
			send_point(ra, rb);
		end
		start = 0;
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/gpt_pkg.sv
hw/rtl/gpt_mulmod.sv
hw/rtl/gaussian_prime_test.sv
dv/gaussian_prime_checker.sv
dv/gaussian_prime_test_test.sv
